FILE: sv/bcdep_pkg.sv
// Package for the BCD calendar to epoch seconds core: payload types, calendar
// constants, BCD digit decode and the March-based month offset table.
// No dependencies.
package bcdep_pkg;

   typedef struct packed {
      logic [22:0] time_word;
      logic [23:0] date_word;
   } req_type;

   typedef struct packed {
      logic [31:0] epoch_seconds;
      logic [2:0]  weekday;
   } rsp_type;

   localparam int unsigned EPOCH_WIDTH      = 22;
   localparam logic [21:0] EPOCH_RESET      = 22'd2440588;
   localparam logic [23:0] JDN_OFFSET       = 24'd32045;
   localparam logic [31:0] SECONDS_PER_DAY  = 32'd86400;
   // 2000 for the century plus 4800 for the Julian day shift
   localparam logic [12:0] YEAR_BASE        = 13'd6800;
   localparam logic [8:0]  DAYS_PER_YEAR    = 9'd365;
   // floor(y / 100) == (y * 5243) >> 19 for every 13-bit y
   localparam logic [12:0] DIV100_RECIP     = 13'd5243;
   localparam int unsigned DIV100_SHIFT     = 19;
   localparam logic [11:0] SECONDS_PER_HOUR = 12'd3600;
   localparam logic [5:0]  SECONDS_PER_MIN  = 6'd60;

   // tens * 10 + units, digits above nine not flagged
   function automatic logic [7:0] bcd_decode(input logic [7:0] v);
      logic [7:0] tens;
      logic [7:0] units;
      tens  = {4'd0, v[7:4]};
      units = {4'd0, v[3:0]};
      return (tens << 3) + (tens << 1) + units;
   endfunction

   // (153 * m + 2) / 5 for the shifted month m
   function automatic logic [9:0] month_days(input logic [4:0] m);
      logic [9:0] d;
      case (m)
         5'd0:    d = 10'd0;
         5'd1:    d = 10'd31;
         5'd2:    d = 10'd61;
         5'd3:    d = 10'd92;
         5'd4:    d = 10'd122;
         5'd5:    d = 10'd153;
         5'd6:    d = 10'd184;
         5'd7:    d = 10'd214;
         5'd8:    d = 10'd245;
         5'd9:    d = 10'd275;
         5'd10:   d = 10'd306;
         5'd11:   d = 10'd337;
         5'd12:   d = 10'd367;
         5'd13:   d = 10'd398;
         5'd14:   d = 10'd428;
         5'd15:   d = 10'd459;
         5'd16:   d = 10'd490;
         5'd17:   d = 10'd520;
         5'd18:   d = 10'd551;
         5'd19:   d = 10'd581;
         5'd20:   d = 10'd612;
         5'd21:   d = 10'd643;
         5'd22:   d = 10'd673;
         default: d = 10'd0;
      endcase
      return d;
   endfunction

endpackage

FILE: sv/bcd_calendar_to_epoch_seconds_core.sv
// Top level of the BCD calendar to epoch seconds core: a five-stage pipeline
// from a BCD time/date register snapshot to a 32-bit epoch seconds count.
// Depends on bcdep_pkg.

// The core accepts one time/date snapshot per clock unless a stall holds it
// and passes it through the five register stages (BCD decode, Julian day sum,
// epoch subtract, day-to-seconds multiply, final add into the output
// register). A stall on the result side holds every stage; bubbles are
// squeezed out, so the input stalls only when all five stages are full and
// the result side stalls. The epoch register resets to the Unix epoch and
// should be written only while the pipeline is empty.
module bcd_calendar_to_epoch_seconds_core
   import bcdep_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_payload,
   input  logic                   csr_wr_en,
   input  logic [EPOCH_WIDTH-1:0] csr_wr_data
);

   logic [EPOCH_WIDTH-1:0] epoch_ff;

   logic vld1_ff, vld2_ff, vld3_ff, vld4_ff, rsp_valid_ff;
   logic go1, go2, go3, go4, go5;

   // stage 1: decoded fields
   logic [5:0]  s1_hours_ff,  s1_hours_in;
   logic [6:0]  s1_minutes_ff, s1_minutes_in;
   logic [6:0]  s1_seconds_ff, s1_seconds_in;
   logic [12:0] s1_year_ff,   s1_year_in;
   logic [4:0]  s1_month_ff,  s1_month_in;
   logic [5:0]  s1_day_ff,    s1_day_in;
   logic [2:0]  s1_wday_ff;

   // stage 2: Julian day and seconds of day
   logic [23:0] s2_jdn_ff, s2_jdn_in;
   logic [17:0] s2_tod_ff, s2_tod_in;
   logic [2:0]  s2_wday_ff;

   // stage 3: days since epoch
   logic [31:0] s3_days_ff, s3_days_in;
   logic [17:0] s3_tod_ff;
   logic [2:0]  s3_wday_ff;

   // stage 4: day seconds
   logic [31:0] s4_day_secs_ff, s4_day_secs_in;
   logic [17:0] s4_tod_ff;
   logic [2:0]  s4_wday_ff;

   rsp_type rsp_ff, rsp_in;

   assign go5 = !rsp_valid_ff || !rsp_stall;
   assign go4 = !vld4_ff || go5;
   assign go3 = !vld3_ff || go4;
   assign go2 = !vld2_ff || go3;
   assign go1 = !vld1_ff || go2;

   assign req_stall   = !go1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff <= EPOCH_RESET;
      end else if (csr_wr_en) begin
         epoch_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff      <= 1'b0;
         vld2_ff      <= 1'b0;
         vld3_ff      <= 1'b0;
         vld4_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (go1) vld1_ff <= req_valid;
         if (go2) vld2_ff <= vld1_ff;
         if (go3) vld3_ff <= vld2_ff;
         if (go4) vld4_ff <= vld3_ff;
         if (go5) rsp_valid_ff <= vld4_ff;
      end
   end

   // stage 1: BCD decode and March-based year/month shift
   always_comb begin
      logic [7:0] year_bin;
      logic [7:0] month_bin;
      logic [7:0] hours_bin;
      logic [7:0] minutes_bin;
      logic [7:0] seconds_bin;
      logic [7:0] day_bin;
      logic       corr;
      hours_bin     = bcd_decode({2'd0, req_payload.time_word[21:16]});
      minutes_bin   = bcd_decode({1'b0, req_payload.time_word[14:8]});
      seconds_bin   = bcd_decode({1'b0, req_payload.time_word[6:0]});
      year_bin      = bcd_decode(req_payload.date_word[23:16]);
      month_bin     = bcd_decode({3'd0, req_payload.date_word[12:8]});
      day_bin       = bcd_decode({2'd0, req_payload.date_word[5:0]});
      corr          = (month_bin <= 8'd2);
      s1_hours_in   = hours_bin[5:0];
      s1_minutes_in = minutes_bin[6:0];
      s1_seconds_in = seconds_bin[6:0];
      s1_day_in     = day_bin[5:0];
      s1_year_in    = YEAR_BASE + {5'd0, year_bin} - {12'd0, corr};
      if (corr) begin
         s1_month_in = month_bin[4:0] + 5'd9;
      end else begin
         s1_month_in = month_bin[4:0] - 5'd3;
      end
   end

   // stage 2: Gregorian Julian day number and seconds within the day
   always_comb begin
      logic [25:0] cent_prod;
      logic [12:0] cent;
      logic [23:0] years_days;
      cent_prod  = {13'd0, s1_year_ff} * {13'd0, DIV100_RECIP};
      cent       = 13'(cent_prod >> DIV100_SHIFT);
      years_days = {11'd0, s1_year_ff} * {15'd0, DAYS_PER_YEAR};
      s2_jdn_in  = {18'd0, s1_day_ff} + {14'd0, month_days(s1_month_ff)} + years_days
                 + {13'd0, s1_year_ff[12:2]} - {11'd0, cent} + {13'd0, cent[12:2]}
                 - JDN_OFFSET;
      s2_tod_in  = {12'd0, s1_hours_ff} * {6'd0, SECONDS_PER_HOUR}
                 + {11'd0, s1_minutes_ff} * {12'd0, SECONDS_PER_MIN}
                 + {11'd0, s1_seconds_ff};
   end

   // stage 3: subtract the epoch, wrapping
   assign s3_days_in = {8'd0, s2_jdn_ff} - {10'd0, epoch_ff};

   // stage 4: days to seconds, low 32 bits kept
   assign s4_day_secs_in = s3_days_ff * SECONDS_PER_DAY;

   // stage 5: add seconds of day into the output register
   always_comb begin
      rsp_in.epoch_seconds = s4_day_secs_ff + {14'd0, s4_tod_ff};
      rsp_in.weekday       = s4_wday_ff;
   end

   always_ff @(posedge clock) begin
      if (go1) begin
         s1_hours_ff   <= s1_hours_in;
         s1_minutes_ff <= s1_minutes_in;
         s1_seconds_ff <= s1_seconds_in;
         s1_year_ff    <= s1_year_in;
         s1_month_ff   <= s1_month_in;
         s1_day_ff     <= s1_day_in;
         s1_wday_ff    <= req_payload.date_word[15:13];
      end
      if (go2) begin
         s2_jdn_ff  <= s2_jdn_in;
         s2_tod_ff  <= s2_tod_in;
         s2_wday_ff <= s1_wday_ff;
      end
      if (go3) begin
         s3_days_ff <= s3_days_in;
         s3_tod_ff  <= s2_tod_ff;
         s3_wday_ff <= s2_wday_ff;
      end
      if (go4) begin
         s4_day_secs_ff <= s4_day_secs_in;
         s4_tod_ff      <= s3_tod_ff;
         s4_wday_ff     <= s3_wday_ff;
      end
      if (go5) begin
         rsp_ff <= rsp_in;
      end
   end

   // input stalls only with every stage full and the output blocked
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (vld1_ff && vld2_ff && vld3_ff && vld4_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled with room in the pipeline");

   // a blocked stage keeps its item
   a_hold_s2: assert property (@(posedge clock) disable iff (reset)
      (vld2_ff && !go3) |=> (vld2_ff && $stable(s2_jdn_ff) && $stable(s2_tod_ff)))
      else $error("stage 2 item lost while blocked");

   a_hold_s4: assert property (@(posedge clock) disable iff (reset)
      (vld4_ff && !go5) |=> (vld4_ff && $stable(s4_day_secs_ff)))
      else $error("stage 4 item lost while blocked");

   a_weekday: assert property (@(posedge clock) disable iff (reset)
      go1 |=> (s1_wday_ff == $past(req_payload.date_word[15:13])))
      else $error("weekday not captured from date word");

   a_out_sum: assert property (@(posedge clock) disable iff (reset)
      (go5 && vld4_ff) |=>
         (rsp_payload.epoch_seconds == $past(s4_day_secs_ff + {14'd0, s4_tod_ff})))
      else $error("output seconds do not match stage 4");

endmodule

FILE: tb/tb_top.sv
// Self-checking bench for bcd_calendar_to_epoch_seconds_core: a queue-fed driver
// and a clocked monitor compare each result item with a local calendar predictor.
// Depends on bcdep_pkg and the core.
`timescale 1ns / 1ps

module tb_top;
   import bcdep_pkg::*;

   localparam int unsigned MAX_REPORTS      = 10;
   localparam int unsigned WATCHDOG_LIMIT   = 2000;
   localparam int unsigned SETTLE_CYCLES    = 8;
   localparam int unsigned DRAIN_CYCLES     = 20;
   localparam int unsigned LONG_HOLD_AT     = 500;
   localparam int unsigned LONG_HOLD_CYCLES = 300;
   localparam logic [21:0] EPOCH_MAX        = 22'h3FFFFF;

   // calendar constants of the day-number formula
   localparam logic [31:0] DAY_NUMBER_BIAS  = 32'd32045;
   localparam logic [31:0] DAY_SECONDS      = 32'd86400;
   localparam logic [31:0] HOUR_SECONDS     = 32'd3600;
   localparam logic [31:0] MINUTE_SECONDS   = 32'd60;
   localparam logic [31:0] ERA_YEARS        = 32'd6800;
   localparam logic [31:0] MONTH_SPAN_MUL   = 32'd153;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;
   logic    csr_wr_en   = 1'b0;
   logic [EPOCH_WIDTH-1:0] csr_wr_data = '0;

   req_type     pending_snapshots[$];
   rsp_type     expected_stamps[$];
   logic [21:0] epoch_day        = EPOCH_RESET;
   int unsigned items_queued     = 0;
   int unsigned req_issue_count  = 0;
   int unsigned req_accept_count = 0;
   int unsigned rsp_accept_count = 0;
   int unsigned rsp_seen_count   = 0;
   int unsigned req_gap          = 0;
   int unsigned rsp_wait         = 0;
   int unsigned idle_cycles      = 0;
   int unsigned error_count      = 0;
   bit          tx_idle_on       = 1'b1;
   bit          rx_idle_on       = 1'b1;
   bit          long_hold_done   = 1'b0;

   bcd_calendar_to_epoch_seconds_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [31:0] bcd_value(input logic [7:0] v);
      return v[7:4] * 32'd10 + v[3:0];
   endfunction

   function automatic logic [7:0] to_bcd(input int unsigned v);
      logic [7:0] r;
      r[7:4] = 4'(v / 10);
      r[3:0] = 4'(v % 10);
      return r;
   endfunction

   function automatic req_type pack_snapshot(input logic [7:0] yr, input logic [2:0] wd,
                                             input logic [4:0] mo, input logic [5:0] dy,
                                             input logic [5:0] hr, input logic [6:0] mi,
                                             input logic [6:0] se);
      req_type s;
      s.time_word = {1'b0, hr, 1'b0, mi, 1'b0, se};
      s.date_word = {yr, wd, mo, 2'b00, dy};
      return s;
   endfunction

   // Julian day number of the decoded date, less the epoch, scaled to seconds, plus the seconds of day
   function automatic rsp_type calendar_to_stamp(input req_type snap, input logic [21:0] epoch);
      logic [31:0] hr, mi, se, yr, mo, dy, march_fix, yy, mm, jdn;
      rsp_type     r;
      hr = bcd_value({2'b00, snap.time_word[21:16]});
      mi = bcd_value({1'b0, snap.time_word[14:8]});
      se = bcd_value({1'b0, snap.time_word[6:0]});
      yr = bcd_value(snap.date_word[23:16]);
      mo = bcd_value({3'b000, snap.date_word[12:8]});
      dy = bcd_value({2'b00, snap.date_word[5:0]});
      // January and February count as months of the previous year
      march_fix = (mo <= 32'd2) ? 32'd1 : 32'd0;
      yy = yr + ERA_YEARS - march_fix;
      mm = mo + 32'd12 * march_fix - 32'd3;
      jdn = dy + (MONTH_SPAN_MUL * mm + 32'd2) / 32'd5 + 32'd365 * yy
            + yy / 32'd4 - yy / 32'd100 + yy / 32'd400
            - DAY_NUMBER_BIAS - {10'd0, epoch};
      r.epoch_seconds = jdn * DAY_SECONDS + hr * HOUR_SECONDS + mi * MINUTE_SECONDS + se;
      r.weekday       = snap.date_word[15:13];
      return r;
   endfunction

   task automatic note_failure(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t: %s", $realtime, msg);
   endtask

   task automatic offer(input req_type s);
      pending_snapshots.push_back(s);
      items_queued++;
   endtask

   // mostly calendar-shaped snapshots, the rest raw noise in every bit
   task automatic queue_random(input int unsigned n);
      req_type s;
      for (int unsigned i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) < 7) begin
            s = pack_snapshot(to_bcd($urandom_range(0, 99)), 3'($urandom_range(0, 7)),
                              5'(to_bcd($urandom_range(1, 12))),
                              6'(to_bcd($urandom_range(1, 31))),
                              6'(to_bcd($urandom_range(0, 23))),
                              7'(to_bcd($urandom_range(0, 59))),
                              7'(to_bcd($urandom_range(0, 59))));
            s.time_word[22]  = 1'($urandom_range(0, 1));
            s.time_word[15]  = 1'($urandom_range(0, 1));
            s.time_word[7]   = 1'($urandom_range(0, 1));
            s.date_word[7:6] = 2'($urandom_range(0, 3));
         end else begin
            s.time_word = 23'($urandom_range(0, 23'h7FFFFF));
            s.date_word = 24'($urandom_range(0, 24'hFFFFFF));
         end
         offer(s);
      end
   endtask

   // wait for the pipeline to drain, then load a new epoch
   task automatic settle_and_write(input logic [21:0] value);
      while (req_accept_count != items_queued || expected_stamps.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      epoch_day    = value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      offer('0);
      offer('{time_word: 23'h7FFFFF, date_word: 24'hFFFFFF});
      offer(pack_snapshot(8'h00, 3'd6, 5'h01, 6'h01, 6'h00, 7'h00, 7'h00));
      offer(pack_snapshot(8'h99, 3'd4, 5'h12, 6'h31, 6'h23, 7'h59, 7'h59));
      offer(pack_snapshot(8'h24, 3'd4, 5'h02, 6'h29, 6'h12, 7'h30, 7'h45));
      offer(pack_snapshot(8'h00, 3'd2, 5'h02, 6'h29, 6'h00, 7'h00, 7'h01));
      offer(pack_snapshot(8'h38, 3'd2, 5'h01, 6'h19, 6'h03, 7'h14, 7'h07));
      offer(pack_snapshot(8'h70, 3'd1, 5'h03, 6'h01, 6'h00, 7'h00, 7'h00));
      offer(pack_snapshot(8'h15, 3'd3, 5'h1F, 6'h10, 6'h08, 7'h00, 7'h00));
      offer(pack_snapshot(8'h15, 3'd3, 5'h15, 6'h10, 6'h08, 7'h00, 7'h00));
      offer(pack_snapshot(8'h15, 3'd3, 5'h0F, 6'h10, 6'h08, 7'h00, 7'h00));
      // digits above nine in every field
      offer(pack_snapshot(8'h42, 3'd5, 5'h06, 6'h15, 6'h3F, 7'h7F, 7'h7F));
      offer(pack_snapshot(8'hFF, 3'd0, 5'h11, 6'h3F, 6'h1A, 7'h0B, 7'h5C));
      offer(pack_snapshot(8'h9A, 3'd7, 5'h0A, 6'h0F, 6'h09, 7'h09, 7'h09));
      // only ignored bits set on top of a plain date
      offer('{time_word: 23'h408080, date_word: 24'h0001C1});
      for (int w = 0; w < 8; w++)
         offer(pack_snapshot(8'h25, 3'(w), 5'h07, 6'h04, 6'h11, 7'h22, 7'h33));
      queue_random(200);

      settle_and_write('0);
      rx_idle_on = 1'b0;
      queue_random(200);

      settle_and_write(EPOCH_MAX);
      rx_idle_on = 1'b1;
      tx_idle_on = 1'b0;
      queue_random(250);

      settle_and_write(22'($urandom_range(0, EPOCH_MAX)));
      tx_idle_on = 1'b1;
      queue_random(200);

      settle_and_write(EPOCH_RESET);
      queue_random(200);

      settle_and_write(22'($urandom_range(0, EPOCH_MAX)));
      queue_random(380);

      while (req_accept_count != items_queued || expected_stamps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_stamps.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // driver: hold the item until taken, then idle for the drawn gap
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && req_accept_count != req_issue_count) begin
      end else if (req_gap != 0) begin
         req_valid <= 1'b0;
         req_gap = req_gap - 1;
      end else if (pending_snapshots.size() != 0) begin
         req_payload <= pending_snapshots.pop_front();
         req_valid   <= 1'b1;
         req_issue_count = req_issue_count + 1;
         req_gap = tx_idle_on ? $urandom_range(0, 9) : 0;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver: stall for a drawn count after each item, once for a long stretch
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_accept_count != rsp_seen_count) begin
            rsp_seen_count = rsp_accept_count;
            rsp_wait = rx_idle_on ? $urandom_range(0, 9) : 0;
         end
         if (!long_hold_done && rsp_accept_count >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            rsp_wait = LONG_HOLD_CYCLES;
         end
         rsp_stall <= (rsp_wait != 0);
         if (rsp_wait != 0)
            rsp_wait = rsp_wait - 1;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         // pop before push so a stray result never meets a fresh expectation
         if (rsp_valid && !rsp_stall) begin
            rsp_accept_count <= rsp_accept_count + 1;
            if (expected_stamps.size() == 0) begin
               note_failure($sformatf("unexpected result seconds=%h weekday=%0d",
                                      rsp_payload.epoch_seconds, rsp_payload.weekday));
            end else begin
               want = expected_stamps.pop_front();
               if (rsp_payload.epoch_seconds !== want.epoch_seconds)
                  note_failure($sformatf("epoch_seconds expected %h got %h",
                                         want.epoch_seconds, rsp_payload.epoch_seconds));
               if (rsp_payload.weekday !== want.weekday)
                  note_failure($sformatf("weekday expected %0d got %0d",
                                         want.weekday, rsp_payload.weekday));
            end
         end
         if (req_valid && !req_stall) begin
            req_accept_count <= req_accept_count + 1;
            expected_stamps.push_back(calendar_to_stamp(req_payload, epoch_day));
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("watchdog: no handshake for %0d cycles", idle_cycles);
               $display("Test completed with failures");
               $finish;
            end
         end
      end
   end

endmodule

FILE: sim.f
sv/bcdep_pkg.sv
sv/bcd_calendar_to_epoch_seconds_core.sv
tb/tb_top.sv
